@@ rtl/masked_length_prefix_deframer_macros.svh @@
// Assertion macros for the deframer checker
`ifndef MASKED_LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define MASKED_LENGTH_PREFIX_DEFRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define MLPD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Consequent must hold in the cycle after the antecedent
`define MLPD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

@@ rtl/mlpd_pkg.sv @@
// Shared types and codes for the masked length-prefix deframer
package mlpd_pkg;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] CFG_ID_KEY  = 2'd0;
    localparam logic [1:0] CFG_LEN_KEY = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN = 2'd2;

    localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

    // index of the sixth header byte
    localparam logic [2:0] HDR_LAST_IDX = 3'd5;

    typedef struct packed {
        logic [15:0] id_key;
        logic [31:0] len_key;
        logic [31:0] max_len;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] msg_id;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last;
    } result_t;

endpackage

@@ rtl/mlpd_cfg_regs.sv @@
// Configuration registers: mask keys and maximum payload length
module mlpd_cfg_regs
    import mlpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_ID_KEY:  cfg_next.id_key  = cfg_wdata[15:0];
                CFG_LEN_KEY: cfg_next.len_key = cfg_wdata;
                CFG_MAX_LEN: cfg_next.max_len = cfg_wdata;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.id_key  <= '0;
            cfg_reg.len_key <= '0;
            cfg_reg.max_len <= MAX_LEN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/mlpd_parser.sv @@
// Header/payload parser state and per-word decode
module mlpd_parser
    import mlpd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       item_valid,
    input  logic [7:0] rx_byte,
    input  logic       link_error,
    output logic       res_valid,
    output result_t    res
);

    logic [2:0]  hdr_count_reg,  hdr_count_next;
    logic [39:0] hdr_shift_reg,  hdr_shift_next;
    logic [31:0] remaining_reg,  remaining_next;
    logic        in_payload_reg, in_payload_next;
    logic        closed_reg,     closed_next;

    logic [47:0] header;
    logic [15:0] id;
    logic [31:0] len;

    // bytes arrive at the top of the shift line, so after five words it
    // holds header bytes 0..4 in order and the current word completes it
    assign header = {rx_byte, hdr_shift_reg};
    assign id     = header[15:0] ^ cfg.id_key;
    assign len    = header[47:16] ^ cfg.len_key;

    always_comb begin
        hdr_count_next  = hdr_count_reg;
        hdr_shift_next  = hdr_shift_reg;
        remaining_next  = remaining_reg;
        in_payload_next = in_payload_reg;
        closed_next     = closed_reg;
        res_valid       = 1'b0;
        res             = '0;
        if (item_valid && !closed_reg) begin
            if (link_error) begin
                hdr_count_next  = '0;
                hdr_shift_next  = '0;
                remaining_next  = '0;
                in_payload_next = 1'b0;
                closed_next     = 1'b1;
                res_valid       = 1'b1;
                res.kind        = KIND_ERROR;
            end else if (in_payload_reg) begin
                remaining_next   = remaining_reg - 32'd1;
                res_valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = rx_byte;
                if (remaining_reg == 32'd1) begin
                    in_payload_next = 1'b0;
                    res.last        = 1'b1;
                end
            end else if (hdr_count_reg != HDR_LAST_IDX) begin
                hdr_shift_next = {rx_byte, hdr_shift_reg[39:8]};
                hdr_count_next = hdr_count_reg + 3'd1;
            end else begin
                hdr_count_next = '0;
                hdr_shift_next = '0;
                res_valid      = 1'b1;
                res.msg_id     = id;
                if (len > cfg.max_len) begin
                    res.kind           = KIND_ERROR;
                    res.payload_length = len;
                    remaining_next     = '0;
                    closed_next        = 1'b1;
                end else if (len == 32'd0) begin
                    res.kind = KIND_HEADER;
                    res.last = 1'b1;
                end else begin
                    res.kind           = KIND_HEADER;
                    res.payload_length = len;
                    in_payload_next    = 1'b1;
                    remaining_next     = len;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_count_reg  <= '0;
            hdr_shift_reg  <= '0;
            remaining_reg  <= '0;
            in_payload_reg <= 1'b0;
            closed_reg     <= 1'b0;
        end else begin
            hdr_count_reg  <= hdr_count_next;
            hdr_shift_reg  <= hdr_shift_next;
            remaining_reg  <= remaining_next;
            in_payload_reg <= in_payload_next;
            closed_reg     <= closed_next;
        end
    end

endmodule

@@ rtl/masked_length_prefix_deframer.sv @@
// Masked length-prefix deframer: top level with input and result registers
// Accepts one stream word per clock while no result waits on m_tready and
// gives at most one result per word. A word is captured in an input register,
// decoded combinationally against the parser state and written to the result
// register. The input register also serves as a one-word skid: one more word
// is taken while a result waits on m_tready.
// After a length error or a link error the stream stays closed until reset;
// words are still accepted but give no result.
module masked_length_prefix_deframer
    import mlpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] link_error
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [15:0] msg_id, [47:16] payload_length,
                                   // [55:48] payload_byte
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    cfg_t    cfg;
    logic    res_valid;
    result_t res;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg,  in_byte_next;
    logic       in_err_reg,   in_err_next;

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg,   out_res_next;

    logic out_free;
    logic advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    mlpd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mlpd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (advance),
        .rx_byte    (in_byte_reg),
        .link_error (in_err_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_err_next   = in_err_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_byte_next  = s_tdata;
            in_err_next   = s_tuser[0];
        end
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (out_free) begin
            out_valid_next = advance && res_valid;
            out_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        in_byte_reg <= in_byte_next;
        in_err_reg  <= in_err_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.payload_byte, out_res_reg.payload_length,
                       out_res_reg.msg_id};
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.last;

endmodule

@@ rtl/mlpd_checker.sv @@
// Port-level checks for the deframer and their binding to the top level
`include "masked_length_prefix_deframer_macros.svh"

module mlpd_checker
    import mlpd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result word holds
    `MLPD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // nothing follows a delivered error: the stream is closed
    `MLPD_ASSERT_NEXT(a_closed_after_err, aclk, aresetn, m_tvalid && m_tready && m_tuser == KIND_ERROR, !m_tvalid)

    `MLPD_ASSERT_SAME(a_err_not_last, aclk, aresetn, m_tvalid && m_tuser == KIND_ERROR, !m_tlast && m_tdata[55:48] == 8'd0)

    // payload words carry no id or length
    `MLPD_ASSERT_SAME(a_payload_clean, aclk, aresetn, m_tvalid && m_tuser == KIND_PAYLOAD, m_tdata[47:0] == 48'd0)

    // zero-length header ends the message, any other header does not
    `MLPD_ASSERT_SAME(a_hdr_last, aclk, aresetn, m_tvalid && m_tuser == KIND_HEADER, m_tlast == (m_tdata[47:16] == 32'd0))

endmodule

bind masked_length_prefix_deframer mlpd_checker u_mlpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
